// ===== src/edge_pair_affinity_accumulator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the edge-pair affinity accumulator
// Implication checks on the rising clock edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef EDGE_PAIR_AFFINITY_ACCUMULATOR_CORE_ASSERT_SVH
`define EDGE_PAIR_AFFINITY_ACCUMULATOR_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define EPAA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("epaa assertion failed");
// next-cycle implication
`define EPAA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("epaa assertion failed");
`else
`define EPAA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define EPAA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/epaa_pkg.sv =====
// ----------------------------------------------------------------------------
// epaa_pkg
// Shared widths, codes and types of the edge-pair affinity accumulator.
// ----------------------------------------------------------------------------
package epaa_pkg;

    localparam int MAX_NODES_DEF = 8;

    localparam int IDX_W     = 3;   // node index in an edge
    localparam int RC_W      = 6;   // read row / column
    localparam int NODE_W    = 4;   // node count register
    localparam int FEAT_W    = 16;  // Q1.15 feature
    localparam int PROD_W    = 32;  // Q2.30 product
    localparam int ACC_W     = 40;  // Q10.30 accumulator
    localparam int ROWC_W    = 8;   // row / column before range cut
    localparam int CFG_IDX_W = 1;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    localparam logic [NODE_W-1:0] NODES_RESET = NODE_W'(8);

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODES_ONE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODES_TWO = 1'b1;

    typedef enum logic [1:0] {
        REQ_ACC   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    // decoded request, decode -> core
    typedef struct packed {
        t_req req;
        logic oor;   // index out of range: no store write, range status
    } t_dec;

endpackage

// ===== src/epaa_decode.sv =====
// ----------------------------------------------------------------------------
// epaa_decode
// Range checks on node and entry indices and store address generation.
// ----------------------------------------------------------------------------
module epaa_decode #(
    parameter int  MAX_NODES   = epaa_pkg::MAX_NODES_DEF,
    localparam int STORE_DIM   = MAX_NODES * MAX_NODES,
    localparam int STORE_DEPTH = STORE_DIM * STORE_DIM,
    localparam int DIM_W       = $clog2(STORE_DIM),
    localparam int ADDR_W      = $clog2(STORE_DEPTH)
) (
    input  epaa_pkg::t_req                 i_req,
    input  logic [epaa_pkg::IDX_W-1:0]     i_edge_one_from,
    input  logic [epaa_pkg::IDX_W-1:0]     i_edge_one_to,
    input  logic [epaa_pkg::IDX_W-1:0]     i_edge_two_from,
    input  logic [epaa_pkg::IDX_W-1:0]     i_edge_two_to,
    input  logic [epaa_pkg::RC_W-1:0]      i_read_row,
    input  logic [epaa_pkg::RC_W-1:0]      i_read_col,
    input  logic [epaa_pkg::NODE_W-1:0]    i_nodes_one,
    input  logic [epaa_pkg::NODE_W-1:0]    i_nodes_two,
    output epaa_pkg::t_dec                 o_dec,
    output logic [ADDR_W-1:0]              o_addr
);
    import epaa_pkg::*;

    logic [NODE_W-1:0]   n1;
    logic [NODE_W-1:0]   n2;
    logic [2*NODE_W-1:0] nmatch;
    logic                acc_oor;
    logic                read_oor;
    logic [ROWC_W-1:0]   row_acc;
    logic [ROWC_W-1:0]   col_acc;
    logic [ROWC_W-1:0]   row_sel;
    logic [ROWC_W-1:0]   col_sel;
    logic [DIM_W-1:0]    row_cut;
    logic [DIM_W-1:0]    col_cut;
    logic                oor;

    // node counts above MAX_NODES act as MAX_NODES
    assign n1 = ({1'b0, i_nodes_one} > (NODE_W+1)'(MAX_NODES)) ?
                NODE_W'(MAX_NODES) : i_nodes_one;
    assign n2 = ({1'b0, i_nodes_two} > (NODE_W+1)'(MAX_NODES)) ?
                NODE_W'(MAX_NODES) : i_nodes_two;
    assign nmatch = (2*NODE_W)'(n1) * (2*NODE_W)'(n2);

    // range checks
    assign acc_oor = ({1'b0, i_edge_one_from} >= n1) || ({1'b0, i_edge_one_to} >= n1) ||
                     ({1'b0, i_edge_two_from} >= n2) || ({1'b0, i_edge_two_to} >= n2);
    assign read_oor = ((2*NODE_W)'(i_read_row) >= nmatch) ||
                      ((2*NODE_W)'(i_read_col) >= nmatch);

    // row i + a*n1, column j + b*n1
    assign row_acc = ROWC_W'(i_edge_one_from) + ROWC_W'(i_edge_two_from) * ROWC_W'(n1);
    assign col_acc = ROWC_W'(i_edge_one_to)   + ROWC_W'(i_edge_two_to)   * ROWC_W'(n1);

    always_comb begin
        row_sel = row_acc;
        col_sel = col_acc;
        oor     = 1'b0;
        unique case (i_req)
            REQ_ACC: begin
                oor = acc_oor;
            end
            REQ_READ: begin
                row_sel = ROWC_W'(i_read_row);
                col_sel = ROWC_W'(i_read_col);
                oor     = read_oor;
            end
            default: begin
                oor = 1'b0;
            end
        endcase
    end

    // in-range rows and columns are below STORE_DIM
    assign row_cut = DIM_W'(row_sel);
    assign col_cut = DIM_W'(col_sel);

    always_comb begin
        if (oor || (i_req != REQ_ACC && i_req != REQ_READ)) begin
            o_addr = '0;
        end else begin
            o_addr = ADDR_W'(row_cut) * ADDR_W'(STORE_DIM) + ADDR_W'(col_cut);
        end
    end

    assign o_dec.req = i_req;
    assign o_dec.oor = oor;

endmodule

// ===== src/epaa_ram.sv =====
// ----------------------------------------------------------------------------
// epaa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module epaa_ram #(
    parameter int  DEPTH  = 4096,
    parameter int  DATA_W = 40,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/edge_pair_affinity_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// edge_pair_affinity_accumulator_core
// Graph-matching affinity matrix in an internal RAM: accumulates Q1.15 feature
// products with saturation, reads single entries and clears the whole store.
//
//   Channel  Dir  Handshake                 Payload
//   s        in   i_s_tvalid / o_s_tready   tdata: edges, features, read row/col
//                                           tuser: request type
//   m        out  o_m_tvalid / i_m_tready   tdata: entry value; tuser: status
//   cfg      in   i_cfg_valid / o_cfg_ready index 0 nodes_one, 1 nodes_two
//
// One word per cycle while the result side keeps up; each word is one RAM
// read-modify-write, with the write result forwarded to a following word
// that hits the same entry. A word passes stage one, then the output register.
// After reset and after each clear word, a sweep zeroes the RAM one entry a
// cycle (all STORE_DEPTH entries, 4096 with MAX_NODES = 8); s is not ready then.
// Config writes are taken in any cycle. A stalled m side holds the pipeline.
// ----------------------------------------------------------------------------
`include "edge_pair_affinity_accumulator_core_assert.svh"

module edge_pair_affinity_accumulator_core #(
    parameter int MAX_NODES = epaa_pkg::MAX_NODES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tdata, from bit 0: edge_one_from[3], edge_one_to[3], edge_two_from[3],
    // edge_two_to[3], feature_one[16], feature_two[16], read_row[6], read_col[6]
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [epaa_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input  logic [epaa_pkg::S_TUSER_W-1:0]    i_s_tuser,   // req_type[2]
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [epaa_pkg::M_TDATA_W-1:0]    o_m_tdata,   // entry_value[40]
    output logic [epaa_pkg::M_TUSER_W-1:0]    o_m_tuser,   // status[2]
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [epaa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [epaa_pkg::NODE_W-1:0]       i_cfg_data
);
    import epaa_pkg::*;

    localparam int STORE_DIM   = MAX_NODES * MAX_NODES;
    localparam int STORE_DEPTH = STORE_DIM * STORE_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // configuration
    logic [NODE_W-1:0]        r_nodes_one;
    logic [NODE_W-1:0]        r_nodes_two;

    // input fields
    t_req                     in_req;
    logic signed [FEAT_W-1:0] in_feat_one;
    logic signed [FEAT_W-1:0] in_feat_two;
    logic signed [PROD_W-1:0] in_prod;
    t_dec                     dec;
    logic [ADDR_W-1:0]        dec_addr;

    // pipeline
    logic                     s_accept;
    logic                     s1_fire;
    logic                     s1_we;
    logic                     r_s1_valid;
    t_req                     r_s1_req;
    logic                     r_s1_oor;
    logic [ADDR_W-1:0]        r_s1_addr;
    logic signed [PROD_W-1:0] r_s1_prod;
    logic                     r_fwd_hit;
    logic [ACC_W-1:0]         r_fwd_data;

    // update
    logic [ACC_W-1:0]         ram_rdata;
    logic [ACC_W-1:0]         n_old;
    logic [ACC_W:0]           n_sum;
    logic                     n_sat;
    logic [ACC_W-1:0]         n_new;
    logic [ACC_W-1:0]         n_value;
    t_status                  n_status;

    // output register
    logic                     r_out_valid;
    logic [ACC_W-1:0]         r_out_data;
    t_status                  r_out_status;

    // clearing sweep
    logic                     r_clr_busy;
    logic [ADDR_W-1:0]        r_clr_addr;
    logic                     clr_last;

    // RAM port
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [ACC_W-1:0]         ram_wdata;

    // unpack the input word
    assign in_req      = t_req'(i_s_tuser);
    assign in_feat_one = i_s_tdata[27:12];
    assign in_feat_two = i_s_tdata[43:28];
    assign in_prod     = in_feat_one * in_feat_two;

    epaa_decode #(
        .MAX_NODES (MAX_NODES)
    ) u_decode (
        .i_req           (in_req),
        .i_edge_one_from (i_s_tdata[2:0]),
        .i_edge_one_to   (i_s_tdata[5:3]),
        .i_edge_two_from (i_s_tdata[8:6]),
        .i_edge_two_to   (i_s_tdata[11:9]),
        .i_read_row      (i_s_tdata[49:44]),
        .i_read_col      (i_s_tdata[55:50]),
        .i_nodes_one     (r_nodes_one),
        .i_nodes_two     (r_nodes_two),
        .o_dec           (dec),
        .o_addr          (dec_addr)
    );

    // handshakes
    assign s1_fire     = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_clr_busy && (!r_s1_valid || s1_fire);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign s1_we       = s1_fire && (r_s1_req == REQ_ACC) && !r_s1_oor;
    assign o_cfg_ready = 1'b1;

    // read-modify-write: forwarded value where the previous word wrote here
    assign n_old = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign n_sum = {n_old[ACC_W-1], n_old} +
                   {{(ACC_W+1-PROD_W){r_s1_prod[PROD_W-1]}}, r_s1_prod};
    assign n_sat = (n_sum[ACC_W] != n_sum[ACC_W-1]);

    always_comb begin
        if (!n_sat) begin
            n_new = n_sum[ACC_W-1:0];
        end else if (n_sum[ACC_W]) begin
            n_new = ACC_MIN;
        end else begin
            n_new = ACC_MAX;
        end
    end

    // result of the word in stage one
    always_comb begin
        n_value  = '0;
        n_status = ST_OK;
        unique case (r_s1_req)
            REQ_ACC: begin
                if (r_s1_oor) begin
                    n_status = ST_RANGE;
                end else if (n_sat) begin
                    n_status = ST_SAT;
                end
            end
            REQ_READ: begin
                if (r_s1_oor) begin
                    n_status = ST_RANGE;
                end else begin
                    n_value = n_old;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // RAM write: sweep has the port while it runs
    assign ram_we    = r_clr_busy || s1_we;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign ram_wdata = r_clr_busy ? '0 : n_new;
    assign clr_last  = (r_clr_addr == ADDR_W'(STORE_DEPTH - 1));

    epaa_ram #(
        .DEPTH  (STORE_DEPTH),
        .DATA_W (ACC_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (s_accept),
        .i_raddr (dec_addr),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes_one <= NODES_RESET;
            r_nodes_two <= NODES_RESET;
            r_s1_valid  <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_out_valid <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_NODES_ONE: r_nodes_one <= i_cfg_data;
                    CFG_NODES_TWO: r_nodes_two <= i_cfg_data;
                    default:       r_nodes_one <= r_nodes_one;
                endcase
            end

            if (s_accept) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= s1_we && (dec_addr == r_s1_addr);
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
                r_fwd_hit  <= 1'b0;
            end

            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            // zeroing sweep after reset and after a clear word
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (clr_last) begin
                    r_clr_busy <= 1'b0;
                end
            end else if (s_accept && dec.req == REQ_CLEAR) begin
                r_clr_busy <= 1'b1;
                r_clr_addr <= '0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_req   <= dec.req;
            r_s1_oor   <= dec.oor;
            r_s1_addr  <= dec_addr;
            r_s1_prod  <= in_prod;
            r_fwd_data <= n_new;
        end
        if (s1_fire) begin
            r_out_data   <= n_value;
            r_out_status <= n_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

    // checks
    `EPAA_ASSERT_IMP(a_no_accept_in_sweep, i_clk, i_rst_n, r_clr_busy, !s_accept)
    `EPAA_ASSERT_NXT(a_sweep_ends, i_clk, i_rst_n, r_clr_busy && clr_last, !r_clr_busy)
    `EPAA_ASSERT_NXT(a_result_registered, i_clk, i_rst_n, s1_fire, r_out_valid)
    `EPAA_ASSERT_IMP(a_no_write_on_stall, i_clk, i_rst_n, !r_clr_busy && !s1_fire, !ram_we)
    `EPAA_ASSERT_IMP(a_fwd_has_word, i_clk, i_rst_n, r_fwd_hit, r_s1_valid)

endmodule
